// File: design/cps_pkg.sv
// Shared constants, command codes and status bundle for the process scheduler.
package cps_pkg;

	localparam int MAX_PROCS = 32;
	localparam int ID_W      = $clog2(MAX_PROCS + 1);
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Scheduling modes.
	localparam logic [1:0] MODE_RR   = 2'd0;
	localparam logic [1:0] MODE_SJF  = 2'd1;
	localparam logic [1:0] MODE_PPRI = 2'd2;
	localparam logic [1:0] MODE_NPRI = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

	// Item kinds.
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_RR_SCAN,
		OP_RR_SLICE,
		OP_RR_POP,
		OP_PICK,
		OP_DECIDE,
		OP_DISPATCH,
		OP_RUN,
		OP_OUT
	} op_t;

	// Status returned by the datapath.
	typedef struct packed {
		logic       scan_done;
		logic       slice_expire;
		logic       cur_zero;
		logic       fifo_empty;
		logic       pop_stale;
		logic       go_dispatch;
		logic       out_busy;
		logic [1:0] mode;
	} stat_t;

endpackage

// File: design/cps_datapath.sv
// Process table, ready queue, counters and result register of the scheduler.
module cps_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cps_pkg::op_t                      op,
	output cps_pkg::stat_t                    stat,
	input  logic [cps_pkg::ID_W-1:0]          proc_id,
	input  logic [15:0]                       arrival_time,
	input  logic [15:0]                       burst_time,
	input  logic [7:0]                        priority_level,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cps_pkg::CFG_DAT_W-1:0]     cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [31:0]                       time_now,
	output logic [cps_pkg::ID_W-1:0]          running_id,
	output logic                              dispatched,
	output logic                              all_done,
	output logic [31:0]                       wait_total
);

	localparam int MP   = cps_pkg::MAX_PROCS;
	localparam int IDW  = cps_pkg::ID_W;
	localparam int IXW  = cps_pkg::IDX_W;

	// Per-process storage.
	logic [15:0]     arr_q [MP];
	logic [15:0]     rem_q [MP];
	logic [7:0]      pri_q [MP];
	logic [31:0]     pre_q [MP];
	logic [IDW-1:0]  fifo_q [MP];
	logic [MP-1:0]   fin_q, start_q, queued_q;

	// Queue pointers, scheduler registers and configuration.
	logic [IXW-1:0]  head_q;
	logic [IXW:0]    len_q;
	logic [IDW-1:0]  cur_q, sel_q, best_q, idx_q, ran_q;
	logic [15:0]     best_key_q, slice_q, ts_q;
	logic [31:0]     tick_q, wsum_q, time_q;
	logic            disp_q;
	logic [1:0]      mode_q;
	logic [5:0]      pcount_q;

	// Result register.
	logic            out_valid_q, out_disp_q, out_done_q;
	logic [31:0]     out_time_q, out_wait_q;
	logic [IDW-1:0]  out_ran_q;

	logic [IDW-1:0]  live_n, addr_id, aid_full, pop_id, pop_full, ld_full, push_id;
	logic [IXW-1:0]  aid, pop_idx, ld_idx, tail;
	logic [15:0]     rd_arr, rd_rem, key;
	logic [7:0]      rd_pri;
	logic [31:0]     rd_pre, wgap;
	logic [32:0]     wsum_ext;
	logic            fin_a, start_a, queued_a, arrived, full, scan_done, push_scan;
	logic            slice_expire, better, load_ok, push_en, pre_en, done_all;
	logic [MP-1:0]   live_mask;

	// Number of live ids, clamped to the table size.
	assign live_n = (pcount_q > 6'(MP)) ? IDW'(MP) : IDW'(pcount_q);

	// One table address per cycle, chosen by the operation.
	always_comb begin
		case (op)
			cps_pkg::OP_RR_SCAN, cps_pkg::OP_PICK: addr_id = idx_q;
			cps_pkg::OP_DISPATCH:                  addr_id = sel_q;
			default:                               addr_id = cur_q;
		endcase
	end

	assign aid_full = addr_id - IDW'(1);
	assign aid      = aid_full[IXW-1:0];
	assign rd_arr   = arr_q[aid];
	assign rd_rem   = rem_q[aid];
	assign rd_pri   = pri_q[aid];
	assign rd_pre   = pre_q[aid];
	assign fin_a    = fin_q[aid];
	assign start_a  = start_q[aid];
	assign queued_a = queued_q[aid];
	assign arrived  = {16'd0, rd_arr} <= tick_q;

	// Queue head and tail.
	assign full     = len_q == (IXW+1)'(MP);
	assign tail     = head_q + len_q[IXW-1:0];
	assign pop_id   = fifo_q[head_q];
	assign pop_full = pop_id - IDW'(1);
	assign pop_idx  = pop_full[IXW-1:0];

	// Scan decisions.
	assign scan_done    = idx_q > live_n;
	assign push_scan    = !scan_done && arrived && !fin_a && !queued_a &&
	                      (idx_q != cur_q) && !full;
	assign slice_expire = (cur_q != '0) && (ts_q != '0) && (slice_q >= ts_q);
	assign key          = mode_q[1] ? {8'd0, rd_pri} : rd_rem;
	assign better       = !scan_done && !fin_a && arrived &&
	                      ((best_q == '0) || (key < best_key_q));

	// Waiting time gained at a dispatch, and the saturating total.
	always_comb begin
		if (start_a)
			wgap = (tick_q >= rd_pre) ? tick_q - rd_pre : 32'd0;
		else
			wgap = arrived ? tick_q - {16'd0, rd_arr} : 32'd0;
	end
	assign wsum_ext = {1'b0, wsum_q} + {1'b0, wgap};

	// Load target.
	assign ld_full = proc_id - IDW'(1);
	assign ld_idx  = ld_full[IXW-1:0];
	assign load_ok = (proc_id != '0) && (proc_id <= IDW'(MP));

	// Queue writes and preemption stamps.
	assign push_en = ((op == cps_pkg::OP_RR_SCAN) && push_scan) ||
	                 ((op == cps_pkg::OP_RR_SLICE) && slice_expire && !full);
	assign push_id = (op == cps_pkg::OP_RR_SCAN) ? idx_q : cur_q;
	assign pre_en  = ((op == cps_pkg::OP_RR_SLICE) && slice_expire) ||
	                 ((op == cps_pkg::OP_DECIDE) && (mode_q == cps_pkg::MODE_PPRI) &&
	                  (best_q != cur_q) && (cur_q != '0) && !fin_a);

	// All live ids finished.
	always_comb begin
		for (int i = 0; i < MP; i++)
			live_mask[i] = IDW'(i) < live_n;
	end
	assign done_all = &(fin_q | ~live_mask);

	// Status to the controller.
	assign stat.scan_done    = scan_done;
	assign stat.slice_expire = slice_expire;
	assign stat.cur_zero     = cur_q == '0;
	assign stat.fifo_empty   = len_q == '0;
	assign stat.pop_stale    = (pop_id > live_n) || fin_q[pop_idx];
	assign stat.go_dispatch  = (best_q != '0) &&
	                           ((mode_q != cps_pkg::MODE_PPRI) || (best_q != cur_q));
	assign stat.out_busy     = out_valid_q;
	assign stat.mode         = mode_q;

	// Table and queue storage.
	always_ff @(posedge clk) begin
		if (op == cps_pkg::OP_LOAD && load_ok) begin
			arr_q[ld_idx] <= arrival_time;
			rem_q[ld_idx] <= burst_time;
			pri_q[ld_idx] <= priority_level;
			pre_q[ld_idx] <= 32'd0;
		end
		if (pre_en)
			pre_q[aid] <= tick_q;
		if (op == cps_pkg::OP_RUN && cur_q != '0)
			rem_q[aid] <= (rd_rem <= 16'd1) ? 16'd0 : rd_rem - 16'd1;
		if (push_en)
			fifo_q[tail] <= push_id;
	end

	// Control state, counters and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q       <= '0;
			start_q     <= '0;
			queued_q    <= '0;
			head_q      <= '0;
			len_q       <= '0;
			cur_q       <= '0;
			sel_q       <= '0;
			best_q      <= '0;
			best_key_q  <= '0;
			idx_q       <= '0;
			ran_q       <= '0;
			slice_q     <= '0;
			tick_q      <= '0;
			wsum_q      <= '0;
			time_q      <= '0;
			disp_q      <= 1'b0;
			mode_q      <= cps_pkg::MODE_RR;
			ts_q        <= 16'd4;
			pcount_q    <= 6'd1;
			out_valid_q <= 1'b0;
			out_disp_q  <= 1'b0;
			out_done_q  <= 1'b0;
			out_time_q  <= '0;
			out_wait_q  <= '0;
			out_ran_q   <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					cps_pkg::REG_MODE:  mode_q   <= cfg_data[1:0];
					cps_pkg::REG_SLICE: ts_q     <= cfg_data;
					cps_pkg::REG_COUNT: pcount_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (op)
				cps_pkg::OP_LOAD: begin
					time_q <= tick_q;
					ran_q  <= '0;
					disp_q <= 1'b0;
					if (load_ok) begin
						fin_q[ld_idx]   <= 1'b0;
						start_q[ld_idx] <= 1'b0;
						if (cur_q == proc_id)
							cur_q <= '0;
					end
				end
				cps_pkg::OP_START: begin
					time_q <= tick_q;
					ran_q  <= '0;
					disp_q <= 1'b0;
					idx_q  <= IDW'(1);
					best_q <= '0;
				end
				cps_pkg::OP_RR_SCAN: begin
					if (push_scan) begin
						queued_q[aid] <= 1'b1;
						len_q         <= len_q + 1'b1;
					end
					if (!scan_done)
						idx_q <= idx_q + 1'b1;
				end
				cps_pkg::OP_RR_SLICE: begin
					if (slice_expire) begin
						if (!full) begin
							queued_q[aid] <= 1'b1;
							len_q         <= len_q + 1'b1;
						end
						cur_q <= '0;
					end
				end
				cps_pkg::OP_RR_POP: begin
					if (len_q != '0) begin
						head_q            <= head_q + 1'b1;
						len_q             <= len_q - 1'b1;
						queued_q[pop_idx] <= 1'b0;
						sel_q             <= pop_id;
					end
				end
				cps_pkg::OP_PICK: begin
					if (better) begin
						best_q     <= idx_q;
						best_key_q <= key;
					end
					if (!scan_done)
						idx_q <= idx_q + 1'b1;
				end
				cps_pkg::OP_DECIDE: begin
					sel_q <= best_q;
					if (mode_q == cps_pkg::MODE_PPRI && best_q != cur_q) begin
						cur_q   <= best_q;
						slice_q <= '0;
					end
				end
				cps_pkg::OP_DISPATCH: begin
					start_q[aid] <= 1'b1;
					wsum_q       <= wsum_ext[32] ? 32'hFFFF_FFFF : wsum_ext[31:0];
					disp_q       <= 1'b1;
					cur_q        <= sel_q;
					slice_q      <= '0;
				end
				cps_pkg::OP_RUN: begin
					ran_q <= cur_q;
					if (cur_q != '0) begin
						if (rd_rem <= 16'd1) begin
							fin_q[aid] <= 1'b1;
							cur_q      <= '0;
						end
						if (slice_q != 16'hFFFF)
							slice_q <= slice_q + 1'b1;
					end
					tick_q <= tick_q + 1'b1;
				end
				cps_pkg::OP_OUT: begin
					out_valid_q <= 1'b1;
					out_time_q  <= time_q;
					out_ran_q   <= ran_q;
					out_disp_q  <= disp_q;
					out_done_q  <= done_all;
					out_wait_q  <= wsum_q;
				end
				default: ;
			endcase
		end
	end

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign time_now   = out_time_q;
	assign running_id = out_ran_q;
	assign dispatched = out_disp_q;
	assign all_done   = out_done_q;
	assign wait_total = out_wait_q;

	// Every queued flag is backed by at least one queue entry.
	a_queued_backed: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(queued_q) <= len_q)
		else $error("queued flags outnumber queue entries");

	// The queue never holds more than the table size.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= (IXW+1)'(MP))
		else $error("ready queue overflow");

	// A result is only reported for an id inside the table.
	a_ran_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_ran_q <= IDW'(MP))
		else $error("running id out of range");

endmodule

// File: design/cps_ctrl.sv
// Sequencing state machine that steps the datapath through one item.
module cps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           action,
	input  cps_pkg::stat_t stat,
	output cps_pkg::op_t   op
);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SLICE, S_POP, S_PICK, S_DECIDE, S_DISP, S_RUN, S_OUT
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE) && !stat.out_busy;
	assign accept   = in_valid && in_ready;

	// Operation for the current step.
	always_comb begin
		case (state_q)
			S_IDLE: begin
				if (!accept)
					op = cps_pkg::OP_NONE;
				else if (action == cps_pkg::ACT_LOAD)
					op = cps_pkg::OP_LOAD;
				else
					op = cps_pkg::OP_START;
			end
			S_SCAN:   op = cps_pkg::OP_RR_SCAN;
			S_SLICE:  op = cps_pkg::OP_RR_SLICE;
			S_POP:    op = cps_pkg::OP_RR_POP;
			S_PICK:   op = cps_pkg::OP_PICK;
			S_DECIDE: op = cps_pkg::OP_DECIDE;
			S_DISP:   op = cps_pkg::OP_DISPATCH;
			S_RUN:    op = cps_pkg::OP_RUN;
			S_OUT:    op = cps_pkg::OP_OUT;
			default:  op = cps_pkg::OP_NONE;
		endcase
	end

	// State sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == cps_pkg::ACT_LOAD)
							state_q <= S_OUT;
						else if (stat.mode == cps_pkg::MODE_RR)
							state_q <= S_SCAN;
						else if (stat.mode == cps_pkg::MODE_PPRI || stat.cur_zero)
							state_q <= S_PICK;
						else
							state_q <= S_RUN;
					end
				end
				S_SCAN: if (stat.scan_done) state_q <= S_SLICE;
				S_SLICE: state_q <= (stat.slice_expire || stat.cur_zero) ? S_POP : S_RUN;
				S_POP: begin
					if (stat.fifo_empty)
						state_q <= S_RUN;
					else if (!stat.pop_stale)
						state_q <= S_DISP;
				end
				S_PICK:   if (stat.scan_done) state_q <= S_DECIDE;
				S_DECIDE: state_q <= stat.go_dispatch ? S_DISP : S_RUN;
				S_DISP:   state_q <= S_RUN;
				S_RUN:    state_q <= S_OUT;
				S_OUT:    state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/cpu_process_scheduler.sv
// Top level of the process scheduler: controller and datapath.
// Each item ends by writing the result register; a load item goes straight there.
// A tick item scans one entry per cycle over ids 1 to count plus one; in round
// robin it checks the slice, pops (again per stale entry dropped), dispatches;
// by key it decides and dispatches; then it runs, or a running job just runs.
// One item is in work at a time; the next is accepted once the result is taken.
// Asynchronous active-low reset clears flags, queue, counters and registers.
module cpu_process_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [cps_pkg::ID_W-1:0]      proc_id,
	input  logic [15:0]                   arrival_time,
	input  logic [15:0]                   burst_time,
	input  logic [7:0]                    priority_level,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   time_now,
	output logic [cps_pkg::ID_W-1:0]      running_id,
	output logic                          dispatched,
	output logic                          all_done,
	output logic [31:0]                   wait_total,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cps_pkg::CFG_DAT_W-1:0] cfg_data
);

	cps_pkg::op_t   op;
	cps_pkg::stat_t stat;

	// Step sequencer.
	cps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.stat     (stat),
		.op       (op)
	);

	// Tables, queue and result register.
	cps_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.stat           (stat),
		.proc_id        (proc_id),
		.arrival_time   (arrival_time),
		.burst_time     (burst_time),
		.priority_level (priority_level),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.time_now       (time_now),
		.running_id     (running_id),
		.dispatched     (dispatched),
		.all_done       (all_done),
		.wait_total     (wait_total)
	);

endmodule

// File: tb/tb_cpu_process_scheduler.sv
// Self-checking testbench for the process scheduler: directed table, then random phases.
module tb_cpu_process_scheduler;
	import cps_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;

	// One result as the block reports it.
	typedef struct packed {
		logic [31:0]     time_now;
		logic [ID_W-1:0] running_id;
		logic            dispatched;
		logic            all_done;
		logic [31:0]     wait_total;
	} sched_res_t;

	// One row of the directed table.
	typedef struct packed {
		logic            act;
		logic [ID_W-1:0] pid;
		logic [15:0]     arr;
		logic [15:0]     bur;
		logic [7:0]      pri;
		logic            typed;
		sched_res_t      res;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, action;
	logic [ID_W-1:0] proc_id;
	logic [15:0] arrival_time, burst_time;
	logic [7:0] priority_level;
	logic out_valid, out_ready;
	logic [31:0] time_now, wait_total;
	logic [ID_W-1:0] running_id;
	logic dispatched, all_done;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	cpu_process_scheduler dut (.*);

	// Scheduler state as predicted.
	logic [15:0] sch_arr [1:MAX_PROCS];
	logic [15:0] sch_rem [1:MAX_PROCS];
	logic [7:0]  sch_pri [1:MAX_PROCS];
	logic [31:0] sch_pre [1:MAX_PROCS];
	bit          sch_fin [1:MAX_PROCS];
	bit          sch_st  [1:MAX_PROCS];
	bit          sch_q   [1:MAX_PROCS];
	int          ready_q [$];
	int          cur_id, slice_cnt;
	logic [31:0] tick_cnt, wait_acc;
	logic [1:0]  cfg_mode;
	int          cfg_slice, cfg_count;

	sched_res_t expected_q [$];
	int errors, cycles, hold_req;
	bit no_gaps;

	// Clock and reset.
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = a + b;
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic void start_proc(int id);
		logic [31:0] w;
		if (!sch_st[id]) begin
			w = (tick_cnt >= sch_arr[id]) ? tick_cnt - sch_arr[id] : 0;
			sch_st[id] = 1;
		end else
			w = (tick_cnt >= sch_pre[id]) ? tick_cnt - sch_pre[id] : 0;
		wait_acc = sat_add(wait_acc, w);
	endfunction

	// Lowest key among arrived, unfinished ids; ties go to the lower id.
	function automatic int pick_lowest(bit by_pri);
		int best, bkey, key;
		best = 0;
		bkey = 0;
		for (int i = 1; i <= cfg_count; i++) begin
			if (sch_fin[i] || sch_arr[i] > tick_cnt)
				continue;
			key = by_pri ? sch_pri[i] : sch_rem[i];
			if (best == 0 || key < bkey) begin
				best = i;
				bkey = key;
			end
		end
		return best;
	endfunction

	function automatic void enqueue(int id);
		if (ready_q.size() >= MAX_PROCS)
			return;
		ready_q.push_back(id);
		sch_q[id] = 1;
	endfunction

	function automatic int dequeue();
		int id;
		if (ready_q.size() == 0)
			return 0;
		id = ready_q.pop_front();
		sch_q[id] = 0;
		return id;
	endfunction

	// Works out the result of one item and advances the predicted state.
	function automatic sched_res_t schedule_step(logic act, int pid, logic [15:0] arr,
			logic [15:0] bur, logic [7:0] pri);
		sched_res_t r;
		int id, ran;
		bit disp, done;
		ran = 0;
		disp = 0;
		r.time_now = tick_cnt;
		if (act == ACT_LOAD) begin
			if (pid >= 1 && pid <= MAX_PROCS) begin
				sch_arr[pid] = arr;
				sch_rem[pid] = bur;
				sch_pri[pid] = pri;
				sch_fin[pid] = 0;
				sch_st[pid] = 0;
				sch_pre[pid] = 0;
				if (cur_id == pid)
					cur_id = 0;
			end
		end else begin
			if (cfg_mode == MODE_RR) begin
				for (int i = 1; i <= cfg_count; i++)
					if (sch_arr[i] <= tick_cnt && !sch_fin[i] && !sch_q[i] && i != cur_id)
						enqueue(i);
				if (cur_id != 0 && cfg_slice != 0 && slice_cnt >= cfg_slice) begin
					sch_pre[cur_id] = tick_cnt;
					enqueue(cur_id);
					cur_id = 0;
				end
				if (cur_id == 0) begin
					id = dequeue();
					while (id != 0 && (id > cfg_count || sch_fin[id]))
						id = dequeue();
					if (id != 0) begin
						cur_id = id;
						slice_cnt = 0;
						start_proc(id);
						disp = 1;
					end
				end
			end else if (cfg_mode == MODE_PPRI) begin
				id = pick_lowest(1);
				if (id != cur_id) begin
					if (cur_id != 0 && !sch_fin[cur_id])
						sch_pre[cur_id] = tick_cnt;
					cur_id = id;
					slice_cnt = 0;
					if (id != 0) begin
						start_proc(id);
						disp = 1;
					end
				end
			end else if (cur_id == 0) begin
				id = pick_lowest(cfg_mode == MODE_NPRI);
				if (id != 0) begin
					cur_id = id;
					slice_cnt = 0;
					start_proc(id);
					disp = 1;
				end
			end
			ran = cur_id;
			if (cur_id != 0) begin
				if (sch_rem[cur_id] <= 1) begin
					sch_rem[cur_id] = 0;
					sch_fin[cur_id] = 1;
					cur_id = 0;
				end else
					sch_rem[cur_id]--;
				if (slice_cnt < 16'hFFFF)
					slice_cnt++;
			end
			tick_cnt = tick_cnt + 1;
		end
		done = 1;
		for (int i = 1; i <= cfg_count; i++)
			if (!sch_fin[i])
				done = 0;
		r.running_id = ran;
		r.dispatched = disp;
		r.all_done = done;
		r.wait_total = wait_acc;
		return r;
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int pick_gap();
		if (no_gaps)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
	endfunction

	// Offers one item and waits for it to be taken.
	task automatic send_item(logic act, int pid, logic [15:0] arr, logic [15:0] bur,
			logic [7:0] pri, bit typed, sched_res_t typed_res);
		int gap;
		sched_res_t r;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		action <= act;
		proc_id <= pid;
		arrival_time <= arr;
		burst_time <= bur;
		priority_level <= pri;
		do @(posedge clk); while (!in_ready);
		r = schedule_step(act, pid, arr, bur, pri);
		expected_q.push_back(typed ? typed_res : r);
	endtask

	task automatic send_rand(logic act, int pid, logic [15:0] arr, logic [15:0] bur,
			logic [7:0] pri);
		send_item(act, pid, arr, bur, pri, 0, '0);
	endtask

	// Register write, only once the block is idle.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		in_valid <= 0;
		@(posedge clk);
		wait (expected_q.size() == 0);
		repeat (6) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			REG_MODE:  cfg_mode = val[1:0];
			REG_SLICE: cfg_slice = val;
			REG_COUNT: cfg_count = val[5:0];
			default: ;
		endcase
	endtask

	// Result checking and receiver stalls.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		sched_res_t e;
		if (!arst_n) begin
			out_ready <= 0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (time_now !== e.time_now) begin
						$error("time_now exp %0d got %0d", e.time_now, time_now);
						errors++;
					end
					if (running_id !== e.running_id) begin
						$error("running_id exp %0d got %0d", e.running_id, running_id);
						errors++;
					end
					if (dispatched !== e.dispatched) begin
						$error("dispatched exp %0d got %0d", e.dispatched, dispatched);
						errors++;
					end
					if (all_done !== e.all_done) begin
						$error("all_done exp %0d got %0d", e.all_done, all_done);
						errors++;
					end
					if (wait_total !== e.wait_total) begin
						$error("wait_total exp %0d got %0d", e.wait_total, wait_total);
						errors++;
					end
				end
			end
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end else if (stall_left == 0 && $urandom_range(0, 299) == 0)
				stall_left = $urandom_range(20, 80);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 0;
			end else
				out_ready <= no_gaps ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	// Directed rows: typed results where they are obvious.
	row_t dir_tab [] = '{
		'{ACT_LOAD, 6'd1,  16'd0,     16'd3,     8'd5,   1, '{0, 0, 0, 0, 0}},
		'{ACT_LOAD, 6'd0,  16'hFFFF,  16'hFFFF,  8'hFF,  1, '{0, 0, 0, 0, 0}},
		'{ACT_LOAD, 6'd63, 16'hFFFF,  16'hFFFF,  8'hFF,  1, '{0, 0, 0, 0, 0}},
		'{ACT_LOAD, 6'd33, 16'h5555,  16'hAAAA,  8'h55,  1, '{0, 0, 0, 0, 0}},
		'{ACT_TICK, 6'd0,  16'd0,     16'd0,     8'd0,   1, '{0, 1, 1, 0, 0}},
		'{ACT_TICK, 6'd0,  16'd0,     16'd0,     8'd0,   1, '{1, 1, 0, 0, 0}},
		'{ACT_TICK, 6'd0,  16'd0,     16'd0,     8'd0,   1, '{2, 1, 0, 1, 0}},
		'{ACT_TICK, 6'd0,  16'd0,     16'd0,     8'd0,   1, '{3, 0, 0, 1, 0}},
		'{ACT_LOAD, 6'd1,  16'd0,     16'd0,     8'd0,   0, '0},
		'{ACT_TICK, 6'd0,  16'd0,     16'd0,     8'd0,   0, '0},
		'{ACT_TICK, 6'd0,  16'd0,     16'd0,     8'd0,   0, '0},
		'{ACT_LOAD, 6'd32, 16'hFFFF,  16'hFFFF,  8'hFF,  0, '0},
		'{ACT_LOAD, 6'd1,  16'd1,     16'd2,     8'd255, 0, '0},
		'{ACT_TICK, 6'd0,  16'd0,     16'd0,     8'd0,   0, '0},
		'{ACT_TICK, 6'd0,  16'd0,     16'd0,     8'd0,   0, '0},
		'{ACT_TICK, 6'd0,  16'd0,     16'd0,     8'd0,   0, '0},
		'{ACT_LOAD, 6'd1,  16'd0,     16'hFFFF,  8'd0,   0, '0},
		'{ACT_TICK, 6'd0,  16'd0,     16'd0,     8'd0,   0, '0},
		'{ACT_LOAD, 6'd1,  16'd0,     16'd2,     8'd0,   0, '0},
		'{ACT_TICK, 6'd0,  16'd0,     16'd0,     8'd0,   0, '0}
	};

	// Stimulus.
	initial begin
		int pid, sent;
		logic [15:0] arr, bur;
		logic [7:0] pri;
		in_valid = 0; action = ACT_LOAD; proc_id = 0; arrival_time = 0;
		burst_time = 0; priority_level = 0;
		cfg_valid = 0; cfg_index = REG_MODE; cfg_data = 0;
		errors = 0; cycles = 0; hold_req = 0; no_gaps = 0;
		for (int i = 1; i <= MAX_PROCS; i++) begin
			sch_arr[i] = 0; sch_rem[i] = 0; sch_pri[i] = 0; sch_pre[i] = 0;
			sch_fin[i] = 0; sch_st[i] = 0; sch_q[i] = 0;
		end
		cur_id = 0; slice_cnt = 0; tick_cnt = 0; wait_acc = 0;
		cfg_mode = MODE_RR; cfg_slice = 4; cfg_count = 1;
		@(posedge arst_n);
		@(posedge clk);

		foreach (dir_tab[i])
			send_item(dir_tab[i].act, dir_tab[i].pid, dir_tab[i].arr, dir_tab[i].bur,
				dir_tab[i].pri, dir_tab[i].typed, dir_tab[i].res);

		// Every id loaded before any wider count is used.
		for (int i = 1; i <= MAX_PROCS; i++)
			send_rand(ACT_LOAD, i, tick_cnt[15:0], $urandom_range(1, 6), $urandom_range(0, 255));

		sent = 0;
		for (int ph = 0; sent < 570; ph++) begin
			write_reg(REG_MODE, ph % 4);
			case (ph % 5)
				0: write_reg(REG_SLICE, 1);
				1: write_reg(REG_SLICE, 16'hFFFF);
				default: write_reg(REG_SLICE, $urandom_range(1, 5));
			endcase
			case (ph % 4)
				0: write_reg(REG_COUNT, MAX_PROCS);
				1: write_reg(REG_COUNT, 1);
				default: write_reg(REG_COUNT, $urandom_range(2, 12));
			endcase
			// The receiver holds off while items keep coming.
			if (ph == 0)
				hold_req = 400;
			no_gaps = (ph % 6 == 5);
			// Fresh jobs for the live ids, then mostly ticks with some reloads.
			for (int i = 1; i <= cfg_count && i <= 8; i++) begin
				send_rand(ACT_LOAD, $urandom_range(1, cfg_count), tick_cnt[15:0] +
					$urandom_range(0, 4), $urandom_range(1, 6), $urandom_range(0, 255));
				sent++;
			end
			for (int k = 0; k < 40; k++) begin
				case ($urandom_range(0, 19))
					0, 1, 2: begin
						pid = $urandom_range(1, MAX_PROCS);
						arr = tick_cnt[15:0] + $urandom_range(0, 6);
						bur = $urandom_range(0, 8);
						pri = $urandom_range(0, 255);
						case ($urandom_range(0, 9))
							0: bur = 16'hFFFF;
							1: arr = 16'hFFFF;
							2: pri = 8'd0;
							3: pri = 8'hFF;
							default: ;
						endcase
						send_rand(ACT_LOAD, pid, arr, bur, pri);
						sent++;
					end
					3: send_rand(ACT_LOAD, $urandom_range(0, 1) ? 0 : $urandom_range(33, 63),
						$urandom, $urandom, $urandom);
					4: begin
						in_valid <= 0;
						@(posedge clk);
						wait (expected_q.size() == 0);
						send_rand(ACT_TICK, $urandom, $urandom, $urandom, $urandom);
						sent++;
					end
					default: begin
						send_rand(ACT_TICK, $urandom, $urandom, $urandom, $urandom);
						sent++;
					end
				endcase
			end
		end
		in_valid <= 0;

		// Drain and finish.
		wait (expected_q.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
